/* rtl/etb_pkg.sv */
// Shared types and constants of the elimination tree builder.
package etb_pkg;

    // Width of every node index field (one based, 0 means "none").
    localparam int NODE_W = 11;

    typedef logic [NODE_W-1:0] node_t;

    // No ancestor yet / no edge.
    localparam node_t NODE_NONE = '0;

endpackage

/* rtl/etb_in_if.sv */
// Input channel: one matrix nonzero per item.
interface etb_in_if;
    logic             valid;
    logic             ready;
    etb_pkg::node_t   column;
    etb_pkg::node_t   neighbor;
    logic             column_start;

    modport source (output valid, output column, output neighbor, output column_start,
                    input ready);
    modport sink   (input valid, input column, input neighbor, input column_start,
                    output ready);
endinterface

/* rtl/etb_out_if.sv */
// Output channel: one tree edge (or none) per item.
interface etb_out_if;
    logic             valid;
    logic             ready;
    logic             linked;
    etb_pkg::node_t   child;
    etb_pkg::node_t   parent_node;

    modport source (output valid, output linked, output child, output parent_node,
                    input ready);
    modport sink   (input valid, input linked, input child, input parent_node,
                    output ready);
endinterface

/* rtl/etb_ram.sv */
// Generic simple dual-port RAM, one write and one registered read port.
module etb_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/elimination_tree_builder.sv */
// Elimination tree builder: ancestor walk with path compression over one RAM.
//
//  channel | dir | payload                          | handshake
//  --------+-----+----------------------------------+-------------------
//  nz      | in  | column, neighbor, column_start   | valid/ready
//  res     | out | linked, child, parent_node       | valid/ready
//
// Steps: an item is taken in S_IDLE; S_WALK then follows one ancestor link per
// RAM read-modify-write until it meets a root or its column; S_DONE hands the
// result on; an item with no walk goes from S_IDLE to S_DONE. Path compression
// keeps walks short. The single-ported-read ancestor RAM sets the pace.
// Reset: asynchronous, active low; the ancestor RAM is not cleared. The user must
// write each entry by its column start before it is read; the block does not enforce it.
// Stalls: a finished edge waits in the output register; the walker holds its
// result until that register frees, and takes one item at a time.
module elimination_tree_builder #(
    parameter int MAX_NODES = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    etb_in_if.sink    nz,
    etb_out_if.source res
);

    localparam int AW = $clog2(MAX_NODES);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_DONE
    } state_t;

    state_t          state_reg;
    etb_pkg::node_t  col_reg;       // column being eliminated
    etb_pkg::node_t  node_reg;      // current node of the walk
    logic            fwd_reg;       // read hit the entry written in the same cycle
    logic            linked_reg;
    etb_pkg::node_t  child_reg;
    logic            out_valid_reg;
    logic            out_linked_reg;
    etb_pkg::node_t  out_child_reg;
    etb_pkg::node_t  out_parent_reg;

    // RAM port signals
    logic                   mem_we;
    logic [AW-1:0]          mem_waddr;
    etb_pkg::node_t         mem_wdata;
    logic                   mem_re;
    logic [AW-1:0]          mem_raddr;
    etb_pkg::node_t         mem_rdata;

    logic            accept;
    logic            col_ok;
    logic            nbr_ok;
    etb_pkg::node_t  next_node;
    logic            next_none;
    logic            next_hit;
    logic            next_ok;

    // Node k is valid in 1..MAX_NODES.
    function automatic logic in_range(input etb_pkg::node_t k);
        return (k != etb_pkg::NODE_NONE) && (32'(k) <= 32'(MAX_NODES));
    endfunction

    // Entry k-1 belongs to node k.
    function automatic logic [AW-1:0] addr_of(input etb_pkg::node_t k);
        logic [31:0] t;
        t = 32'(k) - 32'd1;
        return t[AW-1:0];
    endfunction

    etb_ram #(
        .WIDTH (etb_pkg::NODE_W),
        .DEPTH (MAX_NODES)
    ) u_anc_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign nz.ready = (state_reg == S_IDLE);
    assign accept   = nz.valid && nz.ready;
    assign col_ok   = in_range(nz.column);
    assign nbr_ok   = in_range(nz.neighbor) && (nz.neighbor < nz.column);

    // A self link just rewritten to the column reads back as the column.
    assign next_node = fwd_reg ? col_reg : mem_rdata;
    assign next_none = (next_node == etb_pkg::NODE_NONE);
    assign next_hit  = (next_node == col_reg);
    assign next_ok   = in_range(next_node);

    // RAM access: column-start clear and first read on accept (never the same
    // entry, neighbor < column); then one compress-write and next read per link.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = '0;
        mem_wdata = etb_pkg::NODE_NONE;
        mem_re    = 1'b0;
        mem_raddr = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && col_ok && nz.column_start)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = addr_of(nz.column);
                end
                if (accept && col_ok && nbr_ok)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = addr_of(nz.neighbor);
                end
            end
            S_WALK:
            begin
                if (!next_hit)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = addr_of(node_reg);
                    mem_wdata = col_reg;
                end
                if (!next_hit && !next_none && next_ok)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = addr_of(next_node);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            col_reg        <= etb_pkg::NODE_NONE;
            node_reg       <= etb_pkg::NODE_NONE;
            fwd_reg        <= 1'b0;
            linked_reg     <= 1'b0;
            child_reg      <= etb_pkg::NODE_NONE;
            out_valid_reg  <= 1'b0;
            out_linked_reg <= 1'b0;
            out_child_reg  <= etb_pkg::NODE_NONE;
            out_parent_reg <= etb_pkg::NODE_NONE;
        end
        else
        begin
            // S_DONE reloads the output register itself when it frees
            if (out_valid_reg && res.ready && state_reg != S_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        col_reg  <= nz.column;
                        node_reg <= nz.neighbor;
                        fwd_reg  <= 1'b0;
                        if (col_ok && nbr_ok)
                        begin
                            state_reg <= S_WALK;
                        end
                        else
                        begin
                            linked_reg <= 1'b0;
                            child_reg  <= etb_pkg::NODE_NONE;
                            state_reg  <= S_DONE;
                        end
                    end
                end
                S_WALK:
                begin
                    if (next_hit)
                    begin
                        // walk met the column: edge already present
                        linked_reg <= 1'b0;
                        child_reg  <= etb_pkg::NODE_NONE;
                        state_reg  <= S_DONE;
                    end
                    else if (next_none || !next_ok)
                    begin
                        // root found, linked under the column by this write
                        linked_reg <= 1'b1;
                        child_reg  <= node_reg;
                        state_reg  <= S_DONE;
                    end
                    else
                    begin
                        node_reg <= next_node;
                        fwd_reg  <= (next_node == node_reg);
                    end
                end
                S_DONE:
                begin
                    if (!out_valid_reg || res.ready)
                    begin
                        out_valid_reg  <= 1'b1;
                        out_linked_reg <= linked_reg;
                        out_child_reg  <= child_reg;
                        out_parent_reg <= linked_reg ? col_reg : etb_pkg::NODE_NONE;
                        state_reg      <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign res.valid       = out_valid_reg;
    assign res.linked      = out_linked_reg;
    assign res.child       = out_child_reg;
    assign res.parent_node = out_parent_reg;

endmodule

/* rtl/etb_checker.sv */
// Port-level assertions for the elimination tree builder, bound to the top level.
module etb_checker (
    input logic            clk,
    input logic            rst_n,
    input logic            in_valid,
    input logic            in_ready,
    input logic            out_valid,
    input logic            out_ready,
    input logic            linked,
    input etb_pkg::node_t  child,
    input etb_pkg::node_t  parent_node
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(linked) && $stable(child)
                                    && $stable(parent_node))
        else $error("result changed while stalled");

    // No edge means all-zero payload.
    a_unlinked_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !linked |-> child == etb_pkg::NODE_NONE
                                  && parent_node == etb_pkg::NODE_NONE)
        else $error("unlinked result carries nodes");

    // An edge names two real nodes.
    a_linked_nodes: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && linked |-> child != etb_pkg::NODE_NONE
                                 && parent_node != etb_pkg::NODE_NONE
                                 && child != parent_node)
        else $error("edge with missing or equal nodes");

    // One item in flight: input closes after an accept.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second item taken during a walk");

    // An accepted item gives no result until it has passed through S_DONE.
    a_no_early: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !$rose(out_valid))
        else $error("result appeared one cycle after accept");

endmodule

bind elimination_tree_builder etb_checker u_etb_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (nz.valid),
    .in_ready    (nz.ready),
    .out_valid   (res.valid),
    .out_ready   (res.ready),
    .linked      (res.linked),
    .child       (res.child),
    .parent_node (res.parent_node)
);

/* tb/tb_elimination_tree_builder.sv */
`timescale 1ns / 1ps
// Self-checking testbench of the elimination tree builder: nonzeros in, tree edges out.
module tb_elimination_tree_builder;

    localparam int N_NODES        = 1024;
    localparam int HOLD_CYCLES    = 400;   // long receiver hold-off in the pressure phase
    localparam int WATCHDOG_LIMIT = 5000;  // cycles with no item moved while work is pending
    localparam int TAIL_CYCLES    = 40;

    typedef enum logic [2:0] {
        PH_STEADY,
        PH_SEND_IDLE,
        PH_RECV_STALL,
        PH_BOTH,
        PH_PRESSURE
    } phase_t;

    // One matrix nonzero, as offered on the input channel.
    typedef struct packed {
        etb_pkg::node_t column;
        etb_pkg::node_t neighbor;
        logic           column_start;
    } nonzero_t;

    // One result item: a new tree edge, or all zero.
    typedef struct packed {
        logic           linked;
        etb_pkg::node_t child;
        etb_pkg::node_t parent_node;
    } tree_edge_t;

    logic clk;
    logic rst_n;

    etb_in_if  nz_if();
    etb_out_if res_if();

    elimination_tree_builder #(.MAX_NODES(N_NODES)) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .nz    (nz_if.sink),
        .res   (res_if.source)
    );

    // ------------------------------------------------------------------
    // Predictor state: the ancestor links as the block should hold them.
    // ------------------------------------------------------------------
    etb_pkg::node_t ancestor_of [1:N_NODES];

    // Generator bookkeeping: which entries have been written since reset.
    // A walk is only ever sent when both its column and its neighbor entry
    // are known, so the block never reads an uninitialized RAM word.
    bit written [1:N_NODES];

    nonzero_t   pending_nz[$];
    tree_edge_t expected_edges[$];

    phase_t phase         = PH_STEADY;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;

    int queued_count   = 0;
    int effective_count = 0;   // items with an in-range column
    int accepted_count = 0;
    int mismatches     = 0;
    int stall_cycles   = 0;

    bit nz_taken  = 1'b0;
    int hold_left = 0;
    bit hold_done = 1'b0;

    int last_base = 0;
    int last_n    = 2;

    // Liu's ancestor walk with path compression, for one nonzero.
    function automatic tree_edge_t link_nonzero(etb_pkg::node_t col, etb_pkg::node_t nbr,
                                                logic start);
        tree_edge_t  e;
        int unsigned node;
        int unsigned nxt;
        int unsigned hops;
        bit          hit;
        e    = '0;
        hit  = 1'b0;
        hops = 0;
        if (col < 1 || col > N_NODES)
            return e;
        if (start)
            ancestor_of[col] = etb_pkg::NODE_NONE;
        if (nbr < 1 || nbr > N_NODES || nbr >= col)
            return e;
        node = nbr;
        // Every node passed is pointed at col, so even a cycle ends here.
        while (hops <= N_NODES) begin
            nxt = ancestor_of[node];
            if (nxt == 0)
                break;
            if (nxt == col) begin
                hit = 1'b1;
                break;
            end
            if (nxt < 1 || nxt > N_NODES)
                break;
            ancestor_of[node] = col;
            node = nxt;
            hops++;
        end
        if (!hit) begin
            ancestor_of[node] = col;
            e.linked      = 1'b1;
            e.child       = etb_pkg::node_t'(node);
            e.parent_node = col;
        end
        return e;
    endfunction

    // Queue one nonzero. A walk whose entries were never written is turned
    // into a legal item: the column gets its start, or the neighbor is moved
    // onto the diagonal so no walk happens.
    task automatic queue_nonzero(input int col, input int nbr, input bit start);
        nonzero_t item;
        bit       col_ok;
        bit       walk;
        col_ok = (col >= 1 && col <= N_NODES);
        walk   = col_ok && nbr >= 1 && nbr <= N_NODES && nbr < col;
        if (walk && !written[nbr]) begin
            nbr  = col;
            walk = 1'b0;
        end
        if (walk && !written[col])
            start = 1'b1;
        if (col_ok && start)
            written[col] = 1'b1;
        item.column       = etb_pkg::node_t'(col);
        item.neighbor     = etb_pkg::node_t'(nbr);
        item.column_start = start;
        pending_nz.push_back(item);
        queued_count++;
        if (col_ok)
            effective_count++;
    endtask

    // A well-formed matrix of n columns placed somewhere in the index range:
    // columns in order, each opening with its start item, neighbors below it.
    task automatic queue_matrix(input int n);
        int base;
        int j;
        int m;
        int k;
        int span;
        bit diag_first;
        case ($urandom_range(7))
            0:       base = 0;
            1:       base = N_NODES - n;
            default: base = $urandom_range(0, N_NODES - n);
        endcase
        last_base = base;
        last_n    = n;
        for (j = base + 1; j <= base + n; j++) begin
            m = (j == base + 1) ? 0 : $urandom_range(0, 4);
            diag_first = (m == 0) || ($urandom_range(1) == 0);
            if (diag_first)
                queue_nonzero(j, j, 1'b1);
            for (int t = 0; t < m; t++) begin
                span = j - base - 2;
                if ($urandom_range(1) == 0)
                    k = j - 1 - $urandom_range(0, (span < 2) ? span : 2);
                else
                    k = $urandom_range(base + 1, j - 1);
                queue_nonzero(j, k, !diag_first && t == 0);
            end
            // an upper-triangle entry now and then; the block ignores it
            if ($urandom_range(5) == 0)
                queue_nonzero(j, $urandom_range(j, base + n), 1'b0);
        end
    endtask

    // Random part: mostly matrices, some misuse inside the last matrix
    // (repeats, columns out of order, stray starts), some out-of-range noise.
    task automatic queue_random(input int target);
        int goal;
        int r;
        goal = effective_count + target;
        while (effective_count < goal) begin
            r = $urandom_range(99);
            if (r < 72) begin
                queue_matrix(($urandom_range(9) == 0) ? $urandom_range(30, 60)
                                                      : $urandom_range(2, 20));
            end else if (r < 90) begin
                queue_nonzero(last_base + $urandom_range(1, last_n),
                              last_base + $urandom_range(1, last_n),
                              $urandom_range(3) == 0);
            end else begin
                queue_nonzero(($urandom_range(1) == 0) ? 0 : $urandom_range(N_NODES + 1, 2047),
                              $urandom_range(0, 2047), $urandom_range(1));
            end
        end
    endtask

    task automatic set_phase(input phase_t p, input int send_pct, input int recv_pct);
        phase          = p;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic wait_drained();
        while (pending_nz.size() != 0 || accepted_count != queued_count
               || expected_edges.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Clock
    // ------------------------------------------------------------------
    initial begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Input driver: next item is offered at the falling edge once the
    // current one has been taken (or nothing is being offered).
    // ------------------------------------------------------------------
    always @(negedge clk) begin : nz_driver
        nonzero_t next_nz;
        if (rst_n && (!nz_if.valid || nz_taken)) begin
            if (pending_nz.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_nz = pending_nz.pop_front();
                nz_if.valid        <= 1'b1;
                nz_if.column       <= next_nz.column;
                nz_if.neighbor     <= next_nz.neighbor;
                nz_if.column_start <= next_nz.column_start;
            end else begin
                nz_if.valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: random stalls, plus one long hold-off in the
    // pressure phase so the block backs up into its input.
    // ------------------------------------------------------------------
    always @(negedge clk) begin : res_receiver
        if (hold_left != 0) begin
            res_if.ready <= 1'b0;
            hold_left    <= hold_left - 1;
        end else if (phase == PH_PRESSURE && !hold_done) begin
            res_if.ready <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            hold_done    <= 1'b1;
        end else begin
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Sampling at the rising edge: check results against the oldest
    // expectation, predict every accepted item, and run the watchdog.
    // Results are checked before the new prediction is queued; an item
    // never comes out in the cycle it goes in.
    // ------------------------------------------------------------------
    always @(posedge clk) begin : edge_checker
        tree_edge_t got;
        tree_edge_t want;
        bit         moved;
        moved    = 1'b0;
        nz_taken <= rst_n && nz_if.valid && nz_if.ready;

        if (rst_n && res_if.valid && res_if.ready) begin
            moved           = 1'b1;
            got.linked      = res_if.linked;
            got.child       = res_if.child;
            got.parent_node = res_if.parent_node;
            if (expected_edges.size() == 0) begin
                $display("%0t ERROR: unexpected result: expected none, %s%0b %s%0d %s%0d",
                         $time, "got linked=", got.linked, "child=", got.child,
                         "parent=", got.parent_node);
                mismatches++;
            end else begin
                want = expected_edges.pop_front();
                if (got.linked !== want.linked || got.child !== want.child
                    || got.parent_node !== want.parent_node) begin
                    $display("%0t ERROR: edge mismatch: expected linked=%0b child=%0d parent=%0d,",
                             $time, want.linked, want.child, want.parent_node);
                    $display("%0t        got linked=%0b child=%0d parent=%0d",
                             $time, got.linked, got.child, got.parent_node);
                    mismatches++;
                end
            end
        end

        if (rst_n && nz_if.valid && nz_if.ready) begin
            moved = 1'b1;
            expected_edges.push_back(link_nonzero(nz_if.column, nz_if.neighbor,
                                                  nz_if.column_start));
            accepted_count++;
        end

        // only count while work is outstanding
        if (moved || (pending_nz.size() == 0 && !nz_if.valid && expected_edges.size() == 0)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
            if (stall_cycles >= WATCHDOG_LIMIT) begin
                $display("%0t watchdog: no item moved for %0d cycles", $time, stall_cycles);
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------
    initial begin
        for (int n = 1; n <= N_NODES; n++) begin
            ancestor_of[n] = etb_pkg::NODE_NONE;
            written[n]     = 1'b0;
        end
        nz_if.valid        = 1'b0;
        nz_if.column       = etb_pkg::NODE_NONE;
        nz_if.neighbor     = etb_pkg::NODE_NONE;
        nz_if.column_start = 1'b0;
        res_if.ready       = 1'b0;
        rst_n              = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        set_phase(PH_STEADY, 0, 0);
        // directed: columns out of range give an empty result and touch no entry
        queue_nonzero(0, 0, 1'b1);
        queue_nonzero(2047, 5, 1'b1);
        queue_nonzero(1025, 1, 1'b1);
        // single-entry column, then a plain link and a walk that meets its column
        queue_nonzero(1, 1, 1'b1);
        queue_nonzero(2, 1, 1'b1);
        queue_nonzero(2, 1, 1'b0);
        queue_nonzero(3, 3, 1'b1);
        queue_nonzero(4, 3, 1'b1);
        queue_nonzero(4, 1, 1'b0);      // two-link walk, compresses 1
        // neighbor zero, out of range, above the column
        queue_nonzero(5, 0, 1'b1);
        queue_nonzero(5, 2047, 1'b0);
        queue_nonzero(5, 6, 1'b0);
        queue_nonzero(5, 1, 1'b0);
        queue_nonzero(5, 3, 1'b0);
        // top of the index range
        queue_nonzero(1023, 1023, 1'b1);
        queue_nonzero(1024, 1023, 1'b1);
        queue_nonzero(1024, 1, 1'b0);
        queue_nonzero(1024, 1024, 1'b0);
        queue_nonzero(1024, 1025, 1'b0);
        // misuse: an old column links a later root, closing a cycle that the
        // next walk must resolve as reaching its own column
        queue_nonzero(3, 1, 1'b0);
        queue_nonzero(6, 3, 1'b1);
        queue_nonzero(1024, 3, 1'b0);
        queue_random(100);
        wait_drained();

        set_phase(PH_SEND_IDLE, 82, 0);
        queue_random(80);
        wait_drained();

        set_phase(PH_RECV_STALL, 0, 82);
        queue_random(80);
        wait_drained();

        set_phase(PH_BOTH, 26, 26);
        queue_random(100);
        wait_drained();

        set_phase(PH_PRESSURE, 0, 0);
        queue_random(60);
        wait_drained();

        repeat (TAIL_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
